@@ rtl/mvc_pkg.sv @@
// Shared constants, types and the quarter-wave sine table of the stereo chorus.
`timescale 1ns / 1ps
package mvc_pkg;

  // Delay line geometry
  localparam int LINE_DEPTH = 2048;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int POS_W      = LINE_AW + 8;

  // Modulation
  localparam int MOD_SPAN       = 240;
  localparam int SINE_ADDR_BITS = 10;
  localparam int QTR_LEN        = 1 << (SINE_ADDR_BITS - 2);
  localparam int MIN_DELAY      = 24;
  localparam int BASS_MIN_DELAY = 288;
  localparam int BASS_SCALE     = 36045;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam int PHASE_W = 24;
  localparam int DEPTH_W = 17;
  localparam int SPAN_W  = DEPTH_W + $clog2(MOD_SPAN + 1);

  // Voice phase offsets
  localparam logic [PHASE_W-1:0] VOFF_HALF       = PHASE_W'(64'd1 << (PHASE_W - 1));
  localparam logic [PHASE_W-1:0] VOFF_THIRD      = PHASE_W'((64'd1 << PHASE_W) / 3);
  localparam logic [PHASE_W-1:0] VOFF_TWO_THIRDS = PHASE_W'((64'd2 << PHASE_W) / 3);

  // Exact floor(m / 3) for m below 2^25: (m * DIV3_MUL) >> DIV3_SHIFT
  localparam int DIV3_SHIFT = 26;
  localparam logic [24:0] DIV3_MUL = 25'(((64'd1 << DIV3_SHIFT) + 64'd2) / 3);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;
  localparam logic [CFG_IDX_W-1:0] REG_BASS_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_DELAY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VOICE_COUNT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WET_MIX       = 3'd7;

  typedef logic [QTR_LEN:0][15:0] qtab_t;

  // Quarter-wave sine from a Q30 Taylor series up to x^15
  function automatic qtab_t build_qtab();
    qtab_t tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    for (int k = 0; k <= QTR_LEN; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) >> (SINE_ADDR_BITS - 2);
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      term = ((term * x2) >> 30) / 6;   sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 20;  sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 42;  sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 72;  sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 110; sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 156; sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 210; sum = sum - $signed(term);
      if (sum < 0) sum = 0;
      v = (sum + 64'sd16384) >>> 15;
      if (v > 32767) v = 32767;
      tab[k] = 16'(v);
    end
    return tab;
  endfunction

  localparam qtab_t QSINE = build_qtab();

  // Phase offset of voice v out of n voices
  function automatic logic [PHASE_W-1:0] voice_offset(input logic [1:0] v,
                                                      input logic [1:0] n);
    logic [PHASE_W-1:0] off;
    off = '0;
    case (n)
      2'd2: off = (v == 2'd1) ? VOFF_HALF : '0;
      2'd3: begin
        if (v == 2'd1) off = VOFF_THIRD;
        else if (v == 2'd2) off = VOFF_TWO_THIRDS;
      end
      default: off = '0;
    endcase
    return off;
  endfunction

endpackage

@@ rtl/mvc_if.sv @@
// Stereo frame channels: dry input requests and chorused result requests.
`timescale 1ns / 1ps
interface mvc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_in;
  logic signed [15:0] right_in;
  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface mvc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;
  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

@@ rtl/multi_voice_stereo_chorus.sv @@
// Multi-voice stereo chorus: top level with delay line memories and sequencer.
`timescale 1ns / 1ps
// One request carries a stereo frame; the block answers with one chorused frame.
// A single shared sine/multiply/memory-read sequence serves each voice tap of
// each channel in turn (sine, multiply, address, read, accumulate), followed per
// channel by the divide, products and line write. Each delay line is a 2048 x 16
// synchronous memory with two read addresses; entries not yet written since reset
// read as zero through a fill mark, so there is no clearing pass. A new frame is
// taken only once the last one has left the sequencer, but while its finished
// result still waits.
module multi_voice_stereo_chorus (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mvc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mvc_pkg::CFG_DATA_W-1:0] cfg_data,
  mvc_in_if.sink                        samples,
  mvc_out_if.source                     chorused
);
  import mvc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_SCALE, ST_SINE, ST_MUL, ST_ADDR, ST_READ, ST_ACC,
    ST_DIV, ST_QUOT, ST_MIX, ST_PROD, ST_SUM, ST_OUT
  } state_t;

  // Configuration registers
  logic                bass_mode;
  logic [10:0]         phase_step;
  logic [16:0]         depth;
  logic [18:0]         centre_delay;
  logic [1:0]          voice_count;
  logic [16:0]         stereo_width;
  logic signed [15:0]  feedback_gain;
  logic [16:0]         wet_mix;

  // Control state
  state_t              state;
  logic [PHASE_W-1:0]  lfo_phase;
  logic [LINE_AW-1:0]  write_position;
  logic                wrapped;
  logic                ch;
  logic [1:0]          voice;
  logic                out_valid;

  // Per-frame working registers
  logic signed [15:0]  left_in;
  logic signed [15:0]  right_in;
  logic [PHASE_W-1:0]  right_base;
  logic [32:0]         bass_prod;
  logic [18:0]         centre;
  logic [16:0]         mix;
  logic [1:0]          n_voices;
  logic [SPAN_W-1:0]   deff_span;
  logic signed [15:0]  sine;
  logic signed [SPAN_W+16:0] mod_prod;
  logic [7:0]          frac;
  logic                valid0;
  logic                valid1;
  logic signed [15:0]  rd0;
  logic signed [15:0]  rd1;
  logic signed [25:0]  interp;
  logic signed [26:0]  acc;
  logic [25:0]         mag;
  logic                neg;
  logic [50:0]         quot_prod;
  logic signed [24:0]  wet;
  logic signed [40:0]  fb_prod;
  logic signed [34:0]  dry_prod;
  logic signed [42:0]  wet_prod;
  logic signed [15:0]  left_res;
  logic signed [15:0]  right_res;
  logic signed [15:0]  left_out;
  logic signed [15:0]  right_out;

  // Delay line memories
  logic signed [15:0]  left_mem  [LINE_DEPTH];
  logic signed [15:0]  right_mem [LINE_DEPTH];

  // Combinational helpers
  logic [PHASE_W-1:0]         voice_phase;
  logic [SINE_ADDR_BITS-1:0]  sidx;
  logic [SINE_ADDR_BITS-2:0]  kk;
  logic signed [15:0]         sine_val;
  logic [16:0]                deff;
  logic signed [47:0]         mod_val;
  logic signed [47:0]         delay;
  logic [POS_W-1:0]           rpos;
  logic [LINE_AW-1:0]         addr0;
  logic [LINE_AW-1:0]         addr1;
  logic signed [15:0]         d0;
  logic signed [15:0]         d1;
  logic [23:0]                quot;
  logic signed [15:0]         in_sel;
  logic signed [15:0]         line_word;
  logic signed [15:0]         res_word;

  function automatic logic signed [47:0] rnd_shift(input logic signed [47:0] x,
                                                   input int unsigned s);
    logic [47:0] m;
    m = x[47] ? 48'(-x) : 48'(x);
    m = (m + (48'd1 << (s - 1))) >> s;
    return x[47] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [47:0] x);
    if (x > 48'sd32767) return 16'sh7fff;
    if (x < -48'sd32768) return -16'sh8000;
    return x[15:0];
  endfunction

  // Sine lookup for the current voice
  always_comb begin
    voice_phase = (ch ? right_base : lfo_phase) + voice_offset(voice, n_voices);
    sidx = voice_phase[PHASE_W-1 -: SINE_ADDR_BITS];
    kk = sidx[SINE_ADDR_BITS-2] ?
         (SINE_ADDR_BITS-1)'(QTR_LEN - int'(sidx[SINE_ADDR_BITS-3:0])) :
         (SINE_ADDR_BITS-1)'(sidx[SINE_ADDR_BITS-3:0]);
    sine_val = sidx[SINE_ADDR_BITS-1] ? -$signed(QSINE[kk]) : $signed(QSINE[kk]);
  end

  // Effective depth: the depth register, scaled by BASS_SCALE / 65536 in bass mode
  always_comb begin
    deff = bass_mode ? 17'((bass_prod + 33'd32768) >> 16) : depth;
  end

  // Delay and read position of the current tap
  always_comb begin
    mod_val = rnd_shift(48'(mod_prod), 23);
    delay = $signed({29'd0, centre}) + mod_val;
    if (delay < 48'(MIN_DELAY * 256)) delay = 48'(MIN_DELAY * 256);
    rpos  = POS_W'({write_position, 8'd0}) - delay[POS_W-1:0];
    addr0 = rpos[POS_W-1:8];
    addr1 = addr0 + 1'b1;
  end

  // Mask reads of entries not yet written since reset, average the voices, and form the line and result words
  always_comb begin
    d0 = valid0 ? rd0 : 16'sd0;
    d1 = valid1 ? rd1 : 16'sd0;
    case (n_voices)
      2'd3:    quot = 24'(quot_prod >> DIV3_SHIFT);
      2'd2:    quot = 24'(mag >> 1);
      default: quot = 24'(mag);
    endcase
    in_sel = ch ? right_in : left_in;
    line_word = sat16(rnd_shift((48'(in_sel) <<< 23) + 48'(fb_prod), 23));
    res_word  = sat16(rnd_shift((48'(dry_prod) <<< 8) + 48'(wet_prod), 24));
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bass_mode     <= 1'b0;
      phase_step    <= 11'd210;
      depth         <= 17'd26214;
      centre_delay  <= 19'd98304;
      voice_count   <= 2'd2;
      stereo_width  <= 17'd32768;
      feedback_gain <= 16'sd3277;
      wet_mix       <= 17'd32768;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASS_MODE:     bass_mode     <= cfg_data[0];
        REG_PHASE_STEP:    phase_step    <= cfg_data[10:0];
        REG_DEPTH:         depth         <= cfg_data[16:0];
        REG_CENTRE_DELAY:  centre_delay  <= cfg_data[18:0];
        REG_VOICE_COUNT:   voice_count   <= cfg_data[1:0];
        REG_STEREO_WIDTH:  stereo_width  <= cfg_data[16:0];
        REG_FEEDBACK_GAIN: feedback_gain <= $signed(cfg_data[15:0]);
        REG_WET_MIX:       wet_mix       <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // Delay line read and write ports
  always_ff @(posedge clk) begin
    rd0 <= ch ? right_mem[addr0] : left_mem[addr0];
    rd1 <= ch ? right_mem[addr1] : left_mem[addr1];
    if (state == ST_SUM) begin
      if (ch) right_mem[write_position] <= line_word;
      else    left_mem[write_position]  <= line_word;
    end
  end

  // Frame sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      lfo_phase      <= '0;
      write_position <= '0;
      wrapped        <= 1'b0;
      ch             <= 1'b0;
      voice          <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && chorused.ready && state != ST_OUT) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (samples.valid) begin
            left_in   <= samples.left_in;
            right_in  <= samples.right_in;
            lfo_phase <= lfo_phase + PHASE_W'(phase_step);
            state     <= ST_PREP;
          end
        end
        ST_PREP: begin
          bass_prod  <= 33'(depth) * 33'(BASS_SCALE);
          right_base <= lfo_phase + PHASE_W'({stereo_width, 6'd0});
          centre     <= (bass_mode && centre_delay < 19'(BASS_MIN_DELAY * 256)) ?
                        19'(BASS_MIN_DELAY * 256) : centre_delay;
          if (wet_mix > 17'd65536) mix <= 17'd65536;
          else mix <= wet_mix;
          n_voices   <= (voice_count == 2'd0) ? 2'd1 : voice_count;
          ch         <= 1'b0;
          voice      <= '0;
          state      <= ST_SCALE;
        end
        ST_SCALE: begin
          if (bass_mode && mix > 17'(BASS_SCALE)) mix <= 17'(BASS_SCALE);
          deff_span <= SPAN_W'(deff * MOD_SPAN);
          acc       <= '0;
          state     <= ST_SINE;
        end
        ST_SINE: begin
          sine  <= sine_val;
          state <= ST_MUL;
        end
        ST_MUL: begin
          mod_prod <= $signed({1'b0, deff_span}) * sine;
          state    <= ST_ADDR;
        end
        ST_ADDR: begin
          frac   <= rpos[7:0];
          valid0 <= wrapped || (addr0 < write_position);
          valid1 <= wrapped || (addr1 < write_position);
          state  <= ST_READ;
        end
        ST_READ: begin
          interp <= d0 * $signed({2'b0, 9'(9'd256 - {1'b0, frac})}) +
                    d1 * $signed({3'b0, frac});
          state  <= ST_ACC;
        end
        ST_ACC: begin
          acc <= acc + 27'(interp);
          if (voice == n_voices - 2'd1) begin
            state <= ST_DIV;
          end else begin
            voice <= voice + 2'd1;
            state <= ST_SINE;
          end
        end
        ST_DIV: begin
          neg       <= acc[26];
          mag       <= acc[26] ? 26'(-acc) : 26'(acc);
          state     <= ST_QUOT;
        end
        ST_QUOT: begin
          quot_prod <= 51'(mag) * 51'(DIV3_MUL);
          state     <= ST_MIX;
        end
        ST_MIX: begin
          wet   <= neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
          state <= ST_PROD;
        end
        // Register the feedback and mix products
        ST_PROD: begin
          fb_prod  <= 41'(wet * feedback_gain);
          dry_prod <= 35'(in_sel * $signed({1'b0, 17'(17'd65536 - mix)}));
          wet_prod <= 43'(wet * $signed({1'b0, mix}));
          state    <= ST_SUM;
        end
        ST_SUM: begin
          if (ch) begin
            right_res <= res_word;
            state     <= ST_OUT;
          end else begin
            left_res <= res_word;
            ch       <= 1'b1;
            voice    <= '0;
            acc      <= '0;
            state    <= ST_SINE;
          end
        end
        ST_OUT: begin
          if (!out_valid || chorused.ready) begin
            left_out       <= left_res;
            right_out      <= right_res;
            out_valid      <= 1'b1;
            write_position <= write_position + 1'b1;
            if (write_position == LINE_AW'(LINE_DEPTH - 1)) wrapped <= 1'b1;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign samples.ready      = (state == ST_IDLE);
  assign chorused.valid     = out_valid;
  assign chorused.left_out  = left_out;
  assign chorused.right_out = right_out;

endmodule

@@ rtl/mvc_checker.sv @@
// Port-level checks on the chorus request flow, bound to the top level.
`timescale 1ns / 1ps
module mvc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_left,
  input logic [15:0] out_right
);

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right))
    else $error("stalled result changed");

  // Drop any result on reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Close the input while a frame is in work
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input open right after a request");

  // Raise a result only at the end of a frame's work
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without work");

endmodule

bind multi_voice_stereo_chorus mvc_checker u_mvc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (chorused.valid),
  .out_ready (chorused.ready),
  .out_left  (chorused.left_out),
  .out_right (chorused.right_out)
);
